>>> hw/rtl/nppl_pkg.sv
// ----------------------------------------------------------------------------
// nppl_pkg: shared types and constants of the nth prime power lookup unit
// state codes, controller commands and datapath status
// ----------------------------------------------------------------------------
package nppl_pkg;

	localparam int QI_W = 16;   // query index width
	localparam int PP_W = 12;   // prime power result width

	// bit positions in a sieve map word
	localparam int MAP_PP   = 0;
	localparam int MAP_COMP = 1;
	localparam int MAP_W    = 2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_SCAN_RD,
		ST_SCAN_CHK,
		ST_MARK,
		ST_RANK_RD,
		ST_RANK_CHK,
		ST_LOOKUP,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic q_load;       // capture query index
		logic v_zero;       // value counter to 0
		logic v_two;        // value counter to 2
		logic v_inc;        // value counter + 1
		logic clr_wr;       // clear map word at value counter
		logic map_rd;       // read map word at value counter
		logic prime_wr;     // mark value as prime, load multiple walk
		logic mark_step;    // mark one multiple, advance walk
		logic rank_chk;     // append value to ranked list if prime power
		logic lookup_port;  // read ranked list at port query index
		logic lookup_held;  // read ranked list at captured query index
		logic out_load;     // load result register
	} cmd_t;

	typedef struct packed {
		logic clr_last;     // value counter at last map word
		logic v_end;        // value counter reached limit
		logic is_prime;     // map word read shows no composite mark
		logic m_end;        // multiple walk reached limit
		logic out_free;     // result register can take a new item
	} sts_t;

endpackage

>>> hw/rtl/nth_prime_power_lookup_unit.sv
// ----------------------------------------------------------------------------
// nth_prime_power_lookup_unit: n-th prime power below LIMIT
// result registered from the ranked list read; next query taken once the result is loaded
// first item after reset also builds the table: clearing the sieve map, a scan that marks
// the multiples of each prime, then ranking the prime powers into the ranked list
// asynchronous reset clears control state; the map is cleared by the build itself
// ----------------------------------------------------------------------------
module nth_prime_power_lookup_unit #(
	parameter int LIMIT       = 4096,
	parameter int MAX_ENTRIES = 1024
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [nppl_pkg::QI_W-1:0]  query_index,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       found,
	output logic [nppl_pkg::PP_W-1:0]  prime_power
);

	nppl_pkg::cmd_t cmd;
	nppl_pkg::sts_t sts;

	nppl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	nppl_dp #(
		.LIMIT       (LIMIT),
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.query_index (query_index),
		.out_ready   (out_ready),
		.out_valid   (out_valid),
		.found       (found),
		.prime_power (prime_power)
	);

endmodule

>>> hw/rtl/nppl_ram.sv
// ----------------------------------------------------------------------------
// nppl_ram: generic simple dual port ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module nppl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> hw/rtl/nppl_ctrl.sv
// ----------------------------------------------------------------------------
// nppl_ctrl: sequencer of the nth prime power lookup unit
// builds the table on the first query, then serves lookups
// ----------------------------------------------------------------------------
module nppl_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  nppl_pkg::sts_t  sts,
	output nppl_pkg::cmd_t  cmd
);

	nppl_pkg::state_t state_q, state_d;
	logic built_q, built_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= nppl_pkg::ST_IDLE;
			built_q <= 1'b0;
		end else begin
			state_q <= state_d;
			built_q <= built_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		built_d  = built_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			nppl_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.q_load = 1'b1;
					if (built_q) begin
						cmd.lookup_port = 1'b1;
						state_d         = nppl_pkg::ST_RESP;
					end else begin
						cmd.v_zero = 1'b1;
						state_d    = nppl_pkg::ST_CLEAR;
					end
				end
			end
			nppl_pkg::ST_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (sts.clr_last) begin
					cmd.v_two = 1'b1;
					state_d   = nppl_pkg::ST_SCAN_RD;
				end else begin
					cmd.v_inc = 1'b1;
				end
			end
			nppl_pkg::ST_SCAN_RD: begin
				if (sts.v_end) begin
					cmd.v_two = 1'b1;
					state_d   = nppl_pkg::ST_RANK_RD;
				end else begin
					cmd.map_rd = 1'b1;
					state_d    = nppl_pkg::ST_SCAN_CHK;
				end
			end
			nppl_pkg::ST_SCAN_CHK: begin
				if (sts.is_prime) begin
					cmd.prime_wr = 1'b1;
					state_d      = nppl_pkg::ST_MARK;
				end else begin
					cmd.v_inc = 1'b1;
					state_d   = nppl_pkg::ST_SCAN_RD;
				end
			end
			nppl_pkg::ST_MARK: begin
				if (sts.m_end) begin
					cmd.v_inc = 1'b1;
					state_d   = nppl_pkg::ST_SCAN_RD;
				end else begin
					cmd.mark_step = 1'b1;
				end
			end
			nppl_pkg::ST_RANK_RD: begin
				if (sts.v_end) begin
					built_d = 1'b1;
					state_d = nppl_pkg::ST_LOOKUP;
				end else begin
					cmd.map_rd = 1'b1;
					state_d    = nppl_pkg::ST_RANK_CHK;
				end
			end
			nppl_pkg::ST_RANK_CHK: begin
				cmd.rank_chk = 1'b1;
				cmd.v_inc    = 1'b1;
				state_d      = nppl_pkg::ST_RANK_RD;
			end
			nppl_pkg::ST_LOOKUP: begin
				cmd.lookup_held = 1'b1;
				state_d         = nppl_pkg::ST_RESP;
			end
			nppl_pkg::ST_RESP: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = nppl_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = nppl_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

>>> hw/rtl/nppl_dp.sv
// ----------------------------------------------------------------------------
// nppl_dp: datapath of the nth prime power lookup unit
// sieve map ram, ranked list ram, walk counters and result register
// ----------------------------------------------------------------------------
module nppl_dp #(
	parameter int LIMIT       = 4096,
	parameter int MAX_ENTRIES = 1024
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  nppl_pkg::cmd_t               cmd,
	output nppl_pkg::sts_t               sts,
	input  logic [nppl_pkg::QI_W-1:0]    query_index,
	input  logic                         out_ready,
	output logic                         out_valid,
	output logic                         found,
	output logic [nppl_pkg::PP_W-1:0]    prime_power
);

	localparam int VW = $clog2(LIMIT);                       // value width
	localparam int MW = 2 * VW;                              // walk width
	localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int EW = $clog2(MAX_ENTRIES + 1);             // entry count width
	localparam int CW = (nppl_pkg::QI_W > EW) ? nppl_pkg::QI_W : EW;

	logic [VW:0]                    v_q;
	logic [VW-1:0]                  v_lo;
	logic [MW-1:0]                  m_q;
	logic [MW-1:0]                  pnext_q;
	logic [EW-1:0]                  cnt_q;
	logic [nppl_pkg::QI_W-1:0]      q_q;
	logic                           hit_q;
	logic                           out_valid_q;
	logic                           found_q;
	logic [nppl_pkg::PP_W-1:0]      pp_q;

	logic [MW-1:0]                  vsq;
	logic [MW-1:0]                  pmul;
	logic                           m_is_pow;

	logic                           map_we;
	logic [VW-1:0]                  map_waddr;
	logic [nppl_pkg::MAP_W-1:0]     map_wdata;
	logic [nppl_pkg::MAP_W-1:0]     map_rdata;

	logic                           rank_we;
	logic                           rank_re;
	logic [AW-1:0]                  rank_raddr;
	logic [VW-1:0]                  rank_rdata;
	logic [nppl_pkg::PP_W+VW-1:0]   rank_ext;

	logic [nppl_pkg::QI_W-1:0]      n_sel;
	logic [CW-1:0]                  n_ext;
	logic [CW-1:0]                  idx_ext;
	logic                           hit;
	logic                           list_full;

	assign v_lo      = v_q[VW-1:0];
	assign vsq       = MW'(v_lo) * MW'(v_lo);
	// only the low bits matter: the power being advanced is below limit
	assign pmul      = MW'(pnext_q[VW-1:0]) * MW'(v_lo);
	assign m_is_pow  = (m_q == pnext_q);
	assign list_full = (cnt_q >= EW'(MAX_ENTRIES));

	// map write port: clearing pass, prime itself, or walked multiple
	always_comb begin
		map_we    = cmd.clr_wr | cmd.prime_wr | cmd.mark_step;
		map_waddr = v_lo;
		map_wdata = '0;
		priority if (cmd.mark_step) begin
			map_waddr                      = m_q[VW-1:0];
			map_wdata[nppl_pkg::MAP_COMP] = 1'b1;
			map_wdata[nppl_pkg::MAP_PP]   = m_is_pow;
		end else if (cmd.prime_wr) begin
			map_wdata[nppl_pkg::MAP_PP] = 1'b1;
		end else begin
			map_wdata = '0;
		end
	end

	nppl_ram #(
		.WIDTH (nppl_pkg::MAP_W),
		.DEPTH (LIMIT)
	) u_map_ram (
		.clk   (clk),
		.we    (map_we),
		.waddr (map_waddr),
		.wdata (map_wdata),
		.re    (cmd.map_rd),
		.raddr (v_lo),
		.rdata (map_rdata)
	);

	// lookup index and range check
	assign n_sel      = cmd.lookup_held ? q_q : query_index;
	assign n_ext      = CW'(n_sel);
	assign idx_ext    = n_ext - CW'(1);
	assign hit        = (n_sel != '0) && (n_ext <= CW'(cnt_q));
	assign rank_re    = cmd.lookup_port | cmd.lookup_held;
	assign rank_raddr = idx_ext[AW-1:0];
	assign rank_we    = cmd.rank_chk & map_rdata[nppl_pkg::MAP_PP] & ~list_full;

	nppl_ram #(
		.WIDTH (VW),
		.DEPTH (MAX_ENTRIES)
	) u_rank_ram (
		.clk   (clk),
		.we    (rank_we),
		.waddr (cnt_q[AW-1:0]),
		.wdata (v_lo),
		.re    (rank_re),
		.raddr (rank_raddr),
		.rdata (rank_rdata)
	);

	assign rank_ext = {{nppl_pkg::PP_W{1'b0}}, rank_rdata};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q         <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			priority if (cmd.v_zero) begin
				v_q <= '0;
			end else if (cmd.v_two) begin
				v_q <= (VW+1)'(2);
			end else if (cmd.v_inc) begin
				v_q <= v_q + (VW+1)'(1);
			end
			if (rank_we) begin
				cnt_q <= cnt_q + EW'(1);
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.q_load) begin
			q_q <= query_index;
		end
		// multiple walk starts at v*v, which is also the next power of v
		if (cmd.prime_wr) begin
			m_q     <= vsq;
			pnext_q <= vsq;
		end else if (cmd.mark_step) begin
			m_q <= m_q + MW'(v_lo);
			if (m_is_pow) begin
				pnext_q <= pmul;
			end
		end
		if (rank_re) begin
			hit_q <= hit;
		end
		if (cmd.out_load) begin
			found_q <= hit_q;
			pp_q    <= hit_q ? rank_ext[nppl_pkg::PP_W-1:0] : '0;
		end
	end

	assign sts.clr_last = (v_q == (VW+1)'(LIMIT - 1));
	assign sts.v_end    = (v_q == (VW+1)'(LIMIT));
	assign sts.is_prime = ~map_rdata[nppl_pkg::MAP_COMP];
	assign sts.m_end    = (m_q >= MW'(LIMIT));
	assign sts.out_free = ~out_valid_q | out_ready;

	assign out_valid   = out_valid_q;
	assign found       = found_q;
	assign prime_power = pp_q;

endmodule
